// ----- hdl/kne_pkg.sv -----
// shared types, codes and helpers for the keypad number entry block
package kne_pkg;

    localparam int DIGIT_SLOTS_DEF = 5;
    localparam int CNT_W           = 3;
    localparam int KEY_W           = 4;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int ST_W            = 3;
    localparam int VAL_W           = 17;
    localparam int PROD_W          = 21;

    localparam logic [KEY_W-1:0] KEY_ZERO      = 4'd0;
    localparam logic [KEY_W-1:0] KEY_LAST_DIG  = 4'd9;
    localparam logic [KEY_W-1:0] KEY_OK        = 4'd10;
    localparam logic [KEY_W-1:0] KEY_BACK      = 4'd11;

    localparam logic [ST_W-1:0] ST_EDIT    = 3'd0;
    localparam logic [ST_W-1:0] ST_ACCEPT  = 3'd1;
    localparam logic [ST_W-1:0] ST_CANCEL  = 3'd2;
    localparam logic [ST_W-1:0] ST_DECLINE = 3'd3;
    localparam logic [ST_W-1:0] ST_IGNORE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd2;

    localparam logic      CMD_KEY   = 1'b0;
    localparam logic      CMD_START = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic [CFG_W-1:0] value;
        logic [ST_W-1:0]  status;
        logic             active;
        logic [CNT_W-1:0] digit_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] initial_value;
        logic [CFG_W-1:0] min_value;
        logic [CFG_W-1:0] max_value;
    } t_cfg;

    typedef struct packed {
        logic [VAL_W-1:0] cur_old;
        logic [VAL_W-1:0] cur_new;
        logic             check;
        logic             in_range;
    } t_val_info;

    function automatic logic [PROD_W-1:0] times10(input logic [VAL_W-1:0] v);
        logic [PROD_W-1:0] w;
        w = PROD_W'(v);
        return (w << 3) + (w << 1);
    endfunction

endpackage

// ----- hdl/kne_value.sv -----
// decimal value of the held digits, entry length limit and range check
module kne_value #(
    parameter int DIGIT_SLOTS = kne_pkg::DIGIT_SLOTS_DEF
) (
    input  logic [DIGIT_SLOTS-1:0][kne_pkg::KEY_W-1:0] i_digits,
    input  logic [kne_pkg::CNT_W-1:0]                  i_cnt,
    input  logic [kne_pkg::CNT_W-1:0]                  i_cnt_new,
    input  logic [kne_pkg::KEY_W-1:0]                  i_key,
    input  kne_pkg::t_cfg                              i_cfg,
    output kne_pkg::t_val_info                         o_info
);
    import kne_pkg::*;

    logic [KEY_W-1:0] dig_view [DIGIT_SLOTS];
    logic [VAL_W-1:0] pref     [DIGIT_SLOTS+1];
    logic [CNT_W-1:0] lim;
    logic [VAL_W-1:0] init_ext;
    logic [VAL_W-1:0] min_ext;
    logic [VAL_W-1:0] max_ext;

    assign init_ext = VAL_W'(i_cfg.initial_value);
    assign min_ext  = VAL_W'(i_cfg.min_value);
    assign max_ext  = VAL_W'(i_cfg.max_value);

    // new key sits at the slot the count points to
    always_comb begin
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            dig_view[k] = (CNT_W'(k) == i_cnt) ? i_key : i_digits[k];
        end
        pref[0] = '0;
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            pref[k+1] = VAL_W'(times10(pref[k]) + PROD_W'(dig_view[k]));
        end
    end

    // decimal digit count of max, capped at the slot count
    always_comb begin
        lim = CNT_W'(1)
            + CNT_W'(i_cfg.max_value >= CFG_W'(10))
            + CNT_W'(i_cfg.max_value >= CFG_W'(100))
            + CNT_W'(i_cfg.max_value >= CFG_W'(1000))
            + CNT_W'(i_cfg.max_value >= CFG_W'(10000));
        if (lim > CNT_W'(DIGIT_SLOTS)) begin
            lim = CNT_W'(DIGIT_SLOTS);
        end
    end

    always_comb begin
        o_info.cur_old = init_ext;
        o_info.cur_new = init_ext;
        for (int k = 1; k <= DIGIT_SLOTS; k++) begin
            if (i_cnt == CNT_W'(k)) begin
                o_info.cur_old = pref[k];
            end
            if (i_cnt_new == CNT_W'(k)) begin
                o_info.cur_new = pref[k];
            end
        end
        o_info.check    = (i_cnt_new >= lim)
                       || (times10(o_info.cur_new) > PROD_W'(i_cfg.max_value));
        o_info.in_range = (o_info.cur_new >= min_ext) && (o_info.cur_new <= max_ext);
    end

endmodule

// ----- hdl/kne_step.sv -----
// entry session state: digit store, digit count, open flag and result decode
module kne_step #(
    parameter int DIGIT_SLOTS = kne_pkg::DIGIT_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  kne_pkg::t_in_item  i_item,
    input  kne_pkg::t_cfg      i_cfg,
    output kne_pkg::t_out_item o_result
);
    import kne_pkg::*;

    logic [DIGIT_SLOTS-1:0][KEY_W-1:0] r_digit;
    logic [CNT_W-1:0]                  r_cnt;
    logic                              r_open;
    logic [CNT_W-1:0]                  n_cnt;
    logic                              n_open;
    logic [CNT_W-1:0]                  cnt_new;
    logic                              has_room;
    logic                              wr_en;
    logic [CFG_W-1:0]                  val;
    logic [ST_W-1:0]                   st;
    t_val_info                         info;

    assign has_room = (r_cnt < CNT_W'(DIGIT_SLOTS));
    assign cnt_new  = has_room ? r_cnt + CNT_W'(1) : r_cnt;

    kne_value #(
        .DIGIT_SLOTS(DIGIT_SLOTS)
    ) u_value (
        .i_digits (r_digit),
        .i_cnt    (r_cnt),
        .i_cnt_new(cnt_new),
        .i_key    (i_item.key_code),
        .i_cfg    (i_cfg),
        .o_info   (info)
    );

    always_comb begin
        n_cnt  = r_cnt;
        n_open = r_open;
        wr_en  = 1'b0;
        val    = i_cfg.initial_value;
        st     = ST_EDIT;
        priority if (i_item.cmd == CMD_START) begin
            n_cnt  = '0;
            n_open = 1'b1;
        end else if (!r_open) begin
            st = ST_IGNORE;
        end else if (r_cnt == '0 && i_item.key_code == KEY_ZERO) begin
            n_cnt  = '0;
            n_open = 1'b0;
            st     = ST_CANCEL;
        end else if (i_item.key_code == KEY_BACK) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - CNT_W'(1);
            end else begin
                n_open = 1'b0;
                st     = ST_CANCEL;
            end
        end else if (i_item.key_code == KEY_OK) begin
            val    = CFG_W'(info.cur_old);
            n_cnt  = '0;
            n_open = 1'b0;
            st     = ST_ACCEPT;
        end else if (i_item.key_code > KEY_LAST_DIG) begin
            val    = CFG_W'(info.cur_old);
            n_cnt  = '0;
            n_open = 1'b0;
            st     = ST_CANCEL;
        end else begin
            wr_en = has_room;
            n_cnt = cnt_new;
            if (info.check) begin
                if (info.in_range) begin
                    val = CFG_W'(info.cur_new);
                    st  = ST_ACCEPT;
                end else begin
                    st  = ST_DECLINE;
                end
                n_cnt  = '0;
                n_open = 1'b0;
            end else begin
                val = CFG_W'(info.cur_new);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_open <= 1'b0;
        end else if (i_fire) begin
            r_cnt  <= n_cnt;
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            if (i_fire && wr_en && r_cnt == CNT_W'(k)) begin
                r_digit[k] <= i_item.key_code;
            end
        end
    end

    assign o_result.value       = val;
    assign o_result.status      = st;
    assign o_result.active      = n_open;
    assign o_result.digit_count = n_cnt;

endmodule

// ----- hdl/keypad_number_entry.sv -----
// top level of the keypad number entry block
//
// builds a decimal number from key items. an input item carries a command
// (start a session or key press) and a key code; each accepted item gives
// exactly one result item with value, status, active flag and digit count.
// the input channel is i_valid / o_stall, the result channel o_valid /
// i_stall; an item moves at an edge where valid is high and stall is low.
// the input register holds each taken item, then the session logic and digit
// sum feed the result register that drives o_valid. throughput is one item
// per cycle while the receiver does not stall.
// when the receiver stalls the result register holds, the input register
// still takes one more item, and o_stall rises once both are full.
// configuration writes use i_cfg_valid / o_cfg_ready with a register index
// (0 initial value, 1 min value, 2 max value) and take effect at once;
// other indexes are dropped. write only while the block is idle.
// reset clears the session, the registers and both pipeline stages.
module keypad_number_entry #(
    parameter int DIGIT_SLOTS = kne_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  kne_pkg::t_in_item             i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output kne_pkg::t_out_item            o_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kne_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kne_pkg::CFG_W-1:0]     i_cfg_data
);
    import kne_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item result;
    logic      out_ready;
    logic      in_take;
    logic      fire;

    assign out_ready   = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !out_ready;
    assign in_take     = i_valid && !o_stall;
    assign fire        = r_in_valid && out_ready;
    assign o_cfg_ready = 1'b1;

    kne_step #(
        .DIGIT_SLOTS(DIGIT_SLOTS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_item;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INITIAL: r_cfg.initial_value <= i_cfg_data;
                CFG_MIN:     r_cfg.min_value     <= i_cfg_data;
                CFG_MAX:     r_cfg.max_value     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ----- bench/keypad_number_entry_tb.sv -----
// self-checking bench for keypad_number_entry: directed table, then random entry sessions
`timescale 1ns / 100ps

module keypad_number_entry_tb;
    import kne_pkg::*;

    localparam int DIGIT_SLOTS = DIGIT_SLOTS_DEF;
    localparam int RADIX = 10;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [KEY_W-1:0] KEY_TOP = 4'd15;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_in_item             item;
        logic                 pinned;
        t_out_item            want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in_item             i_item = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out_item            o_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // predictor state
    logic [CFG_W-1:0] init_reg = '0;
    logic [CFG_W-1:0] min_reg = '0;
    logic [CFG_W-1:0] max_reg = '0;
    logic [KEY_W-1:0] digit_q [DIGIT_SLOTS];
    int               n_digits = 0;
    bit               session = 1'b0;

    t_out_item pending_results [$];
    t_out_item pred_item;
    t_out_item want_item;
    t_out_item pin_want = '0;
    bit        pin_flag = 1'b0;

    int errors = 0;
    int items_total = 0;
    int ignored_cnt = 0;
    int effective_cnt = 0;
    int results_seen = 0;
    int cfg_writes = 0;

    int stall_run = 0;
    int stall_pick = 0;
    int hold_req = 0;
    int hold_seen = 0;
    bit stall_on = 1'b1;
    bit gaps_on = 1'b1;

    keypad_number_entry uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned typed_value();
        int unsigned v;
        v = 0;
        if (n_digits == 0) begin
            return init_reg;
        end
        for (int i = 0; i < n_digits; i++) begin
            v = v * RADIX + digit_q[i];
        end
        return v;
    endfunction

    function automatic int digit_limit();
        int          n;
        int unsigned m;
        n = 1;
        m = max_reg;
        while (m >= RADIX) begin
            m = m / RADIX;
            n++;
        end
        if (n > DIGIT_SLOTS) begin
            n = DIGIT_SLOTS;
        end
        return n;
    endfunction

    function automatic void close_entry();
        n_digits = 0;
        session = 1'b0;
    endfunction

    function automatic t_out_item predict_entry(t_in_item it);
        t_out_item       res;
        int unsigned     v;
        int unsigned     shown;
        logic [ST_W-1:0] st;
        shown = init_reg;
        st = ST_EDIT;
        if (it.cmd == CMD_START) begin
            n_digits = 0;
            session = 1'b1;
        end else if (!session) begin
            st = ST_IGNORE;
        end else if (n_digits == 0 && it.key_code == KEY_ZERO) begin
            close_entry();
            st = ST_CANCEL;
        end else if (it.key_code == KEY_BACK) begin
            if (n_digits > 0) begin
                n_digits--;
            end else begin
                close_entry();
                st = ST_CANCEL;
            end
        end else if (it.key_code == KEY_OK) begin
            shown = typed_value();
            close_entry();
            st = ST_ACCEPT;
        end else if (it.key_code > KEY_LAST_DIG) begin
            shown = typed_value();
            close_entry();
            st = ST_CANCEL;
        end else begin
            if (n_digits < DIGIT_SLOTS) begin
                digit_q[n_digits] = it.key_code;
                n_digits++;
            end
            v = typed_value();
            if (n_digits >= digit_limit() || v * RADIX > max_reg) begin
                if (v >= min_reg && v <= max_reg) begin
                    shown = v;
                    st = ST_ACCEPT;
                end else begin
                    st = ST_DECLINE;
                end
                close_entry();
            end else begin
                shown = v;
            end
        end
        res.value = CFG_W'(shown);
        res.status = st;
        res.active = session;
        res.digit_count = CNT_W'(n_digits);
        return res;
    endfunction

    function automatic void report_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_item);
                    errors++;
                end else begin
                    want_item = pending_results.pop_front();
                    report_field("value", want_item.value, o_item.value);
                    report_field("status", want_item.status, o_item.status);
                    report_field("active", want_item.active, o_item.active);
                    report_field("digit_count", want_item.digit_count, o_item.digit_count);
                end
            end
            if (i_valid && !o_stall) begin
                pred_item = predict_entry(i_item);
                if (pred_item.status == ST_IGNORE) begin
                    ignored_cnt++;
                end else begin
                    effective_cnt++;
                end
                pending_results.push_back(pin_flag ? pin_want : pred_item);
                items_total++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            stall_run = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
        end else if (!stall_on) begin
            i_stall <= 1'b0;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 70) begin
                i_stall <= 1'b0;
                stall_run = $urandom_range(0, 6);
            end else if (stall_pick < 95) begin
                i_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                stall_run = $urandom_range(10, 30);
            end
        end
    end

    task automatic send_item(logic cmd, logic [KEY_W-1:0] key, logic pin, t_out_item want);
        int taken_before;
        int gap_len;
        int pick;
        taken_before = items_total;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item <= {cmd, key};
        pin_flag = pin;
        pin_want = want;
        do @(posedge i_clk); while (o_stall);
        wait (items_total != taken_before);
        gap_len = 0;
        if (gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90) begin
                gap_len = $urandom_range(8, 30);
            end else if (pick >= 55) begin
                gap_len = $urandom_range(1, 3);
            end
        end
        repeat (gap_len) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic press(logic cmd, logic [KEY_W-1:0] key);
        send_item(cmd, key, 1'b0, '0);
    endtask

    task automatic drain(int settle);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INITIAL: init_reg = data;
            CFG_MIN:     min_reg = data;
            CFG_MAX:     max_reg = data;
            default:     ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_session();
        int steps;
        int pick;
        press(CMD_START, KEY_W'($urandom_range(0, KEY_TOP)));
        steps = $urandom_range(1, 6);
        for (int s = 0; s < steps && session; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 76) begin
                if (n_digits == 0 && $urandom_range(0, 9) != 0) begin
                    press(CMD_KEY, KEY_W'($urandom_range(1, KEY_LAST_DIG)));
                end else begin
                    press(CMD_KEY, KEY_W'($urandom_range(0, KEY_LAST_DIG)));
                end
            end else if (pick < 90) begin
                press(CMD_KEY, KEY_BACK);
            end else if (pick < 95) begin
                press(CMD_START, KEY_W'($urandom_range(0, KEY_TOP)));
            end else begin
                press(CMD_KEY, KEY_W'($urandom_range(KEY_BACK + 1, KEY_TOP)));
            end
        end
        if (session) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                press(CMD_KEY, KEY_OK);
            end else if (pick < 60) begin
                press(CMD_KEY, KEY_W'($urandom_range(KEY_BACK + 1, KEY_TOP)));
            end
        end
    endtask

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_row item_row(logic cmd, logic [KEY_W-1:0] key);
        t_row row;
        row = '0;
        row.item = {cmd, key};
        return row;
    endfunction

    function automatic t_row pinned_row(logic cmd, logic [KEY_W-1:0] key, logic [CFG_W-1:0] value,
                                        logic [ST_W-1:0] st, logic act, logic [CNT_W-1:0] cnt);
        t_row row;
        row = item_row(cmd, key);
        row.pinned = 1'b1;
        row.want = {value, st, act, cnt};
        return row;
    endfunction

    initial begin
        t_row        script_rows [$];
        int          target;
        int          digits;
        int unsigned lo;
        int unsigned hi;
        int unsigned new_init;
        int unsigned new_min;
        int unsigned new_max;
        bit          paused;
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: closed session, all registers zero
        script_rows.push_back(pinned_row(CMD_KEY, 4'd5, 16'h0000, ST_IGNORE, 1'b0, 3'd0));
        script_rows.push_back(cfg_row(CFG_INITIAL, 16'hFFFF));
        script_rows.push_back(cfg_row(CFG_MIN, 16'h0000));
        script_rows.push_back(cfg_row(CFG_MAX, 16'hFFFF));
        script_rows.push_back(pinned_row(CMD_START, KEY_TOP, 16'hFFFF, ST_EDIT, 1'b1, 3'd0));
        script_rows.push_back(pinned_row(CMD_KEY, KEY_ZERO, 16'hFFFF, ST_CANCEL, 1'b0, 3'd0));
        script_rows.push_back(pinned_row(CMD_START, KEY_ZERO, 16'hFFFF, ST_EDIT, 1'b1, 3'd0));
        script_rows.push_back(pinned_row(CMD_KEY, KEY_BACK, 16'hFFFF, ST_CANCEL, 1'b0, 3'd0));
        script_rows.push_back(item_row(CMD_START, KEY_OK));
        script_rows.push_back(item_row(CMD_KEY, 4'd6));
        script_rows.push_back(item_row(CMD_KEY, 4'd5));
        script_rows.push_back(item_row(CMD_KEY, 4'd5));
        script_rows.push_back(item_row(CMD_KEY, 4'd3));
        script_rows.push_back(pinned_row(CMD_KEY, 4'd6, 16'hFFFF, ST_DECLINE, 1'b0, 3'd0));
        script_rows.push_back(item_row(CMD_START, KEY_BACK));
        script_rows.push_back(pinned_row(CMD_KEY, KEY_OK, 16'hFFFF, ST_ACCEPT, 1'b0, 3'd0));
        script_rows.push_back(item_row(CMD_START, 4'd1));
        script_rows.push_back(item_row(CMD_KEY, 4'd4));
        script_rows.push_back(pinned_row(CMD_START, 4'd12, 16'hFFFF, ST_EDIT, 1'b1, 3'd0));
        script_rows.push_back(item_row(CMD_KEY, 4'd4));
        script_rows.push_back(item_row(CMD_KEY, 4'd13));
        script_rows.push_back(cfg_row(CFG_INITIAL, 16'h0000));
        script_rows.push_back(cfg_row(CFG_MIN, 16'hFFFF));
        script_rows.push_back(item_row(CMD_START, 4'd14));
        script_rows.push_back(item_row(CMD_KEY, 4'd6));
        script_rows.push_back(item_row(CMD_KEY, 4'd5));
        script_rows.push_back(item_row(CMD_KEY, 4'd5));
        script_rows.push_back(item_row(CMD_KEY, 4'd3));
        script_rows.push_back(item_row(CMD_KEY, KEY_BACK));
        script_rows.push_back(item_row(CMD_KEY, 4'd3));
        script_rows.push_back(pinned_row(CMD_KEY, 4'd5, 16'hFFFF, ST_ACCEPT, 1'b0, 3'd0));

        foreach (script_rows[r]) begin
            if (script_rows[r].is_cfg) begin
                drain(4);
                write_reg(script_rows[r].idx, script_rows[r].data);
            end else begin
                send_item(script_rows[r].item.cmd, script_rows[r].item.key_code,
                          script_rows[r].pinned, script_rows[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain(4);
            case (p)
                0: begin
                    new_init = $urandom_range(0, 16'hFFFF);
                    new_min = 0;
                    new_max = 16'hFFFF;
                end
                1: begin
                    new_init = 0;
                    new_min = 0;
                    new_max = 0;
                end
                2: begin
                    new_init = 16'hFFFF;
                    new_min = 16'hFFFF;
                    new_max = 16'hFFFF;
                end
                default: begin
                    digits = $urandom_range(1, DIGIT_SLOTS);
                    lo = 1;
                    repeat (digits - 1) lo = lo * RADIX;
                    hi = lo * RADIX - 1;
                    if (hi > 16'hFFFF) begin
                        hi = 16'hFFFF;
                    end
                    if (digits == 1) begin
                        lo = 0;
                    end
                    new_max = $urandom_range(lo, hi);
                    if ($urandom_range(0, 4) == 0) begin
                        new_min = $urandom_range(new_max, 16'hFFFF);
                    end else begin
                        new_min = $urandom_range(0, new_max);
                    end
                    new_init = $urandom_range(0, 16'hFFFF);
                end
            endcase
            write_reg(CFG_INITIAL, CFG_W'(new_init));
            write_reg(CFG_MIN, CFG_W'(new_min));
            write_reg(CFG_MAX, CFG_W'(new_max));
            if (p == 0) begin
                write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 16'hFFFF)));
            end
            stall_on = (p % 3) != 1;
            gaps_on = (p % 3) != 2;

            // receiver holds off while items keep coming back to back
            if (p == 3) begin
                gaps_on = 1'b0;
                hold_req++;
                target = effective_cnt + 24;
                while (effective_cnt < target) begin
                    run_session();
                end
                gaps_on = 1'b1;
            end

            target = effective_cnt + PHASE_ITEMS;
            while (effective_cnt < target) begin
                if (p == 5 && !paused && effective_cnt >= target - PHASE_ITEMS / 2) begin
                    drain(0);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0) begin
                    press($urandom_range(0, 7) == 0, KEY_W'($urandom_range(0, KEY_TOP)));
                end else begin
                    run_session();
                end
            end
        end

        drain(12);
        $display("covered %0d items (%0d ignored by a closed session), %0d results checked",
                 items_total, ignored_cnt, results_seen);
        $display("%0d register writes over %0d random settings plus the directed ones",
                 cfg_writes, PHASES);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
